### hdl/assert_macros.svh
// assertion macros used by rrt_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define RRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hdl/rrt_pkg.sv
// shared types and constants of the region reservation table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rrt_pkg;

	localparam int ENTRIES      = 16;
	localparam int HEADER_BYTES = 32;
	localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam int ADDR_W  = 32;
	localparam int LEN_W   = 31;
	localparam int OWNER_W = 16;
	// span end without wrap: start + header + length
	localparam int SPAN_W  = ADDR_W + 2;

	localparam logic KIND_RESERVE = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_OVERLAP   = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} rrt_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_COMMIT
	} rrt_state_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  start;
		logic [LEN_W-1:0]   length;
		logic [OWNER_W-1:0] owner;
	} rrt_entry_t;

	typedef struct packed {
		logic             load;
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic             commit;
	} rrt_cmd_t;

	typedef struct packed {
		logic out_busy;
	} rrt_stat_t;

endpackage

`default_nettype wire

### hdl/rrt_ctrl.sv
// controller: sequences accept, table scan and commit of one request
// depends on rrt_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrt_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              out_ready,
	input  wire rrt_pkg::rrt_stat_t stat,
	output rrt_pkg::rrt_cmd_t      cmd
);
	import rrt_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	rrt_state_t       state_q;
	rrt_state_t       state_next;
	logic [IDX_W-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_next;
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.rd_en) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		cmd.rd_idx = idx_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_next = ST_LAST;
				end
			end
			// last entry is being compared
			ST_LAST: begin
				state_next = ST_COMMIT;
			end
			ST_COMMIT: begin
				// wait for the result register to free up
				if (!stat.out_busy || out_ready) begin
					cmd.commit = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### hdl/rrt_datapath.sv
// datapath: request registers, entry memory, valid bits, scan compare and result register
// depends on rrt_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrt_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire rrt_pkg::rrt_cmd_t           cmd,
	output rrt_pkg::rrt_stat_t               stat,
	input  wire logic                        kind,
	input  wire logic [rrt_pkg::ADDR_W-1:0]  start_address,
	input  wire logic [rrt_pkg::LEN_W-1:0]   payload_length,
	input  wire logic [rrt_pkg::OWNER_W-1:0] owner,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [1:0]                       status
);
	import rrt_pkg::*;

	// request held for the whole scan
	logic               kind_q;
	logic [ADDR_W-1:0]  start_q;
	logic [LEN_W-1:0]   len_q;
	logic [OWNER_W-1:0] owner_q;
	logic [SPAN_W-1:0]  end_q;

	rrt_entry_t       entry_mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	rrt_entry_t       rd_s1;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] idx_s1;

	// scan results
	logic              overlap_q;
	logic              found_q;
	logic [IDX_W-1:0]  slot_q;
	logic [ADDR_W-1:0] pick_start_q;

	logic              out_valid_q;
	rrt_status_t       status_q;

	logic              ent_valid;
	logic [SPAN_W-1:0] ent_end;
	logic              ent_overlap;
	logic              owner_hit;
	rrt_status_t       result;

	assign ent_valid   = valid_q[idx_s1];
	assign ent_end     = SPAN_W'(rd_s1.start) + SPAN_W'(HEADER_BYTES) + SPAN_W'(rd_s1.length);
	assign ent_overlap = (SPAN_W'(start_q) < ent_end) && (SPAN_W'(rd_s1.start) < end_q);
	assign owner_hit   = ent_valid && (rd_s1.owner == owner_q)
		&& (!found_q || (rd_s1.start < pick_start_q));

	always_comb begin
		if (kind_q == KIND_RESERVE) begin
			if (overlap_q) begin
				result = STAT_OVERLAP;
			end else if (!found_q) begin
				result = STAT_FULL;
			end else begin
				result = STAT_DONE;
			end
		end else begin
			result = found_q ? STAT_DONE : STAT_NOT_FOUND;
		end
	end

	// request capture and entry memory
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			start_q <= start_address;
			len_q   <= payload_length;
			owner_q <= owner;
			end_q   <= SPAN_W'(start_address) + SPAN_W'(HEADER_BYTES) + SPAN_W'(payload_length);
		end
		if (cmd.rd_en) begin
			rd_s1 <= entry_mem[cmd.rd_idx];
		end
		if (cmd.commit && (kind_q == KIND_RESERVE) && !overlap_q && found_q) begin
			entry_mem[slot_q] <= '{start: start_q, length: len_q, owner: owner_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_vld_s1   <= 1'b0;
			idx_s1      <= '0;
			overlap_q   <= 1'b0;
			found_q     <= 1'b0;
			slot_q      <= '0;
			pick_start_q <= '0;
			out_valid_q <= 1'b0;
			status_q    <= STAT_DONE;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			idx_s1    <= cmd.rd_idx;

			if (cmd.load) begin
				overlap_q <= 1'b0;
				found_q   <= 1'b0;
			end else if (rd_vld_s1) begin
				if (kind_q == KIND_RESERVE) begin
					if (ent_valid && ent_overlap) begin
						overlap_q <= 1'b1;
					end
					// first free slot in index order
					if (!ent_valid && !found_q) begin
						found_q <= 1'b1;
						slot_q  <= idx_s1;
					end
				end else if (owner_hit) begin
					found_q      <= 1'b1;
					slot_q       <= idx_s1;
					pick_start_q <= rd_s1.start;
				end
			end

			if (cmd.commit) begin
				if (kind_q == KIND_RESERVE) begin
					if (!overlap_q && found_q) begin
						valid_q[slot_q] <= 1'b1;
					end
				end else if (found_q) begin
					valid_q[slot_q] <= 1'b0;
				end
				out_valid_q <= 1'b1;
				status_q    <= result;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_busy = out_valid_q;
	assign out_valid     = out_valid_q;
	assign status        = status_q;

endmodule

`default_nettype wire

### hdl/region_reservation_table.sv
// region reservation table: usage
// input channel (in_valid / in_ready) carries kind, start_address, payload_length, owner.
// kind reserve stores the span [start, start + header + length) in the lowest free slot
// unless it overlaps a stored span (status overlap) or no slot is free (status full).
// kind release frees the region of that owner with the lowest start (status not found
// if none). output channel (out_valid / out_ready) carries one status per transaction.
// one request at a time: after acceptance the controller reads the entry memory one
// entry per cycle (ST_SCAN), compares the last entry (ST_LAST), then in ST_COMMIT loads
// the result register once it is free. in_ready returns in the same cycle as out_valid,
// so no new request is accepted until the current one is through.
// the single-port entry memory scan sets the transaction rate.
// a new request is accepted while an earlier result still waits on out_ready; if the
// receiver stalls, the next result is held back until the waiting one is taken.
// reset (arst_n low) empties the table at once and drops any pending result.
// depends on rrt_pkg, rrt_ctrl, rrt_datapath
`timescale 1ns / 1ps
`default_nettype none

module region_reservation_table (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        kind,
	input  wire logic [rrt_pkg::ADDR_W-1:0]  start_address,
	input  wire logic [rrt_pkg::LEN_W-1:0]   payload_length,
	input  wire logic [rrt_pkg::OWNER_W-1:0] owner,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [1:0]                       status
);
	import rrt_pkg::*;

	rrt_cmd_t  cmd;
	rrt_stat_t stat;

	rrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rrt_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.kind           (kind),
		.start_address  (start_address),
		.payload_length (payload_length),
		.owner          (owner),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status)
	);

endmodule

`default_nettype wire

### hdl/rrt_checker.sv
// port-level checks for region_reservation_table, attached by bind
// depends on assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rrt_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] status
);

	// a stalled result holds
	`RRT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status))

	// one request at a time: busy right after a transaction is taken
	`RRT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// ready comes back only together with a loaded result
	`RRT_ASSERT_NOW(a_ready_with_result, clk, arst_n, $rose(in_ready), out_valid)

endmodule

bind region_reservation_table rrt_checker u_rrt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status)
);

`default_nettype wire
